FILE: rtl/u8v_pkg.sv
// u8v_pkg: shared types for the utf-8 stream validator
// second byte rule codes and the per-string checker state
// no dependencies
package u8v_pkg;

    typedef enum logic [2:0] {
        RULE_NONE  = 3'd0,
        RULE_A0_BF = 3'd1,
        RULE_80_9F = 3'd2,
        RULE_90_BF = 3'd3,
        RULE_80_8F = 3'd4
    } rule_t;

    typedef struct packed {
        logic [1:0] owed;
        rule_t      rule;
        logic       err;
    } chk_state_t;

    typedef struct packed {
        logic emit;
        logic verdict;
    } chk_result_t;

    localparam chk_state_t CHK_STATE_CLEAR = '{owed: 2'd0, rule: RULE_NONE, err: 1'b0};

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD3_SURR = 8'hED;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;
    localparam logic [7:0] BOUND_A0   = 8'hA0;
    localparam logic [7:0] BOUND_9F   = 8'h9F;
    localparam logic [7:0] BOUND_90   = 8'h90;
    localparam logic [7:0] BOUND_8F   = 8'h8F;

endpackage

FILE: rtl/utf8_stream_validator.sv
// utf8_stream_validator: strict utf-8 well-formedness check over a byte stream
// top level: input beat register, byte checker, verdict output register
// depends on u8v_pkg and u8v_step
//
// usage
//   slave side takes one byte per beat: tdata = byte, tlast = last byte of the
//   string, tuser = no_byte (beat carries no byte and ends the string; an
//   empty string is a single no_byte beat)
//   master side gives one beat per string, tdata[0] = 1 when the string is
//   well-formed utf-8 without nul bytes
//   a byte is checked once it sits in the input register; when an ending beat
//   leaves that register, its verdict is loaded into the verdict register
//   throughput is one byte per cycle, set by the single register stage that
//   feeds the checker and the one-deep verdict register, except as below:
//   when the master side stalls with a verdict pending, bytes that give no
//   verdict keep flowing; a second ending beat waits in the input register
//   and tready drops until the verdict is taken
//   reset clears the checker state and both valid flags; no clearing pass
module utf8_stream_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
    input  logic       s_axis_tlast,   // last_byte
    input  logic       s_axis_tuser,   // no_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] is_valid, [7:1] zero
);
    import u8v_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        in_none_reg;
    chk_state_t  st_reg;
    chk_state_t  st_next;
    chk_result_t res;
    logic        out_valid_reg;
    logic        out_bit_reg;
    logic        out_free;
    logic        advance;
    logic        s_accept;

    u8v_step u_step (
        .state      (st_reg),
        .byte_value (in_byte_reg),
        .last_byte  (in_last_reg),
        .no_byte    (in_none_reg),
        .state_next (st_next),
        .result     (res)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!res.emit || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            st_reg        <= CHK_STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (advance && res.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
            in_none_reg <= s_axis_tuser;
        end
        if (advance && res.emit)
        begin
            out_bit_reg <= res.verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_bit_reg};

`ifndef ASSERT_OFF
    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.emit) |=> (st_reg.owed == 2'd0 && !st_reg.err))
        else $error("checker state not cleared after verdict");

    a_verdict_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !(advance && res.emit))
        else $error("verdict overwritten while output stalled");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && res.emit && out_valid_reg))
        else $error("input stalled without pending verdict");
`endif

endmodule

FILE: rtl/u8v_step.sv
// u8v_step: combinational check of one byte against the running state
// gives the next state and, at the end of a string, the verdict
// depends on u8v_pkg
module u8v_step (
    input  u8v_pkg::chk_state_t  state,
    input  logic [7:0]           byte_value,
    input  logic                 last_byte,
    input  logic                 no_byte,
    output u8v_pkg::chk_state_t  state_next,
    output u8v_pkg::chk_result_t result
);
    import u8v_pkg::*;

    chk_state_t taken;
    logic       cont_ok;

    always_comb
    begin
        cont_ok = ((byte_value & CONT_MASK) == CONT_TAG);
        unique case (state.rule)
            RULE_A0_BF: cont_ok = cont_ok && (byte_value >= BOUND_A0);
            RULE_80_9F: cont_ok = cont_ok && (byte_value <= BOUND_9F);
            RULE_90_BF: cont_ok = cont_ok && (byte_value >= BOUND_90);
            RULE_80_8F: cont_ok = cont_ok && (byte_value <= BOUND_8F);
            default:    cont_ok = cont_ok;
        endcase
    end

    always_comb
    begin
        taken = state;
        if (!no_byte)
        begin
            if (state.owed != 2'd0)
            begin
                if (!cont_ok)
                begin
                    taken.err = 1'b1;
                end
                taken.owed = state.owed - 2'd1;
                taken.rule = RULE_NONE;
            end
            else if (byte_value == 8'd0)
            begin
                taken.err = 1'b1;
            end
            else if (byte_value <= ASCII_MAX)
            begin
                taken = state;
            end
            else if (byte_value >= LEAD2_LO && byte_value <= LEAD2_HI)
            begin
                taken.owed = 2'd1;
                taken.rule = RULE_NONE;
            end
            else if (byte_value >= LEAD3_LO && byte_value <= LEAD3_HI)
            begin
                taken.owed = 2'd2;
                taken.rule = (byte_value == LEAD3_LO)   ? RULE_A0_BF :
                             (byte_value == LEAD3_SURR) ? RULE_80_9F : RULE_NONE;
            end
            else if (byte_value >= LEAD4_LO && byte_value <= LEAD4_HI)
            begin
                taken.owed = 2'd3;
                taken.rule = (byte_value == LEAD4_LO) ? RULE_90_BF :
                             (byte_value == LEAD4_HI) ? RULE_80_8F : RULE_NONE;
            end
            else
            begin
                taken.err = 1'b1;
            end
        end
    end

    always_comb
    begin
        result.emit    = last_byte || no_byte;
        result.verdict = !taken.err && (taken.owed == 2'd0);
        state_next     = result.emit ? CHK_STATE_CLEAR : taken;
    end

endmodule

FILE: tb/utf8_verdict_checker.sv
// utf8_verdict_checker: watches both stream channels of the utf-8 validator, tracks
// the sequence state of each string and compares every verdict beat in order
// depends on u8v_pkg for the second byte rule codes and byte bounds
module utf8_verdict_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
    input  logic       s_axis_tlast,   // last_byte
    input  logic       s_axis_tuser,   // no_byte
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [0] is_valid, [7:1] zero
    output int         error_count,
    output int         verdicts_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import u8v_pkg::*;

    localparam logic [7:0] NUL_BYTE = 8'h00;

    logic [1:0] cont_owed;
    rule_t      next_rule;
    logic       bad_seen;
    logic       verdict_q[$];

    function automatic logic cont_in_range(input logic [7:0] b, input rule_t r);
        if ((b & CONT_MASK) != CONT_TAG)
        begin
            return 1'b0;
        end
        case (r)
            RULE_A0_BF: return b >= BOUND_A0;
            RULE_80_9F: return b <= BOUND_9F;
            RULE_90_BF: return b >= BOUND_90;
            RULE_80_8F: return b <= BOUND_8F;
            default:    return 1'b1;
        endcase
    endfunction

    task automatic absorb_byte(input logic [7:0] b);
        logic is_lead2;
        logic is_lead3;
        logic is_lead4;
        is_lead2 = (b >= LEAD2_LO) && (b <= LEAD2_HI);
        is_lead3 = (b >= LEAD3_LO) && (b <= LEAD3_HI);
        is_lead4 = (b >= LEAD4_LO) && (b <= LEAD4_HI);
        if (cont_owed != 2'd0)
        begin
            if (!cont_in_range(b, next_rule))
            begin
                bad_seen = 1'b1;
            end
            cont_owed = cont_owed - 2'd1;
            next_rule = RULE_NONE;
        end
        else if (is_lead2)
        begin
            cont_owed = 2'd1;
            next_rule = RULE_NONE;
        end
        else if (is_lead3)
        begin
            cont_owed = 2'd2;
            next_rule = (b == LEAD3_LO) ? RULE_A0_BF :
                        (b == LEAD3_SURR) ? RULE_80_9F : RULE_NONE;
        end
        else if (is_lead4)
        begin
            cont_owed = 2'd3;
            next_rule = (b == LEAD4_LO) ? RULE_90_BF :
                        (b == LEAD4_HI) ? RULE_80_8F : RULE_NONE;
        end
        else if (b == NUL_BYTE || b > ASCII_MAX)
        begin
            bad_seen = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_owed = 2'd0;
            next_rule = RULE_NONE;
            bad_seen = 1'b0;
            verdict_q.delete();
            error_count <= 0;
            verdicts_owed <= 0;
        end
        else
        begin
            int   errs;
            logic want_valid;
            errs = 0;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("verdict beat with no string pending: tdata=%h", m_axis_tdata);
                    errs++;
                end
                else
                begin
                    want_valid = verdict_q.pop_front();
                    if (m_axis_tdata[0] !== want_valid)
                    begin
                        $error("is_valid mismatch: expected %0b, actual %0b",
                               want_valid, m_axis_tdata[0]);
                        errs++;
                    end
                    if (m_axis_tdata[7:1] !== 7'd0)
                    begin
                        $error("tdata padding mismatch: expected %h, actual %h",
                               7'd0, m_axis_tdata[7:1]);
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (!s_axis_tuser)
                begin
                    absorb_byte(s_axis_tdata);
                end
                if (s_axis_tlast || s_axis_tuser)
                begin
                    verdict_q.push_back(!bad_seen && cont_owed == 2'd0);
                    cont_owed = 2'd0;
                    next_rule = RULE_NONE;
                    bad_seen = 1'b0;
                end
            end
            error_count <= error_count + errs;
            verdicts_owed <= verdict_q.size();
        end
    end

endmodule

FILE: tb/utf8_stream_validator_test.sv
// utf8_stream_validator_test: drives byte strings into the utf-8 validator, directed
// edge cases first and then random well-formed and broken strings with random idling
// depends on utf8_stream_validator and utf8_verdict_checker
module utf8_stream_validator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BEAT_TARGET = 1450;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] byte_value
    logic       s_axis_tlast;    // last_byte
    logic       s_axis_tuser;    // no_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [0] is_valid, [7:1] zero
    int         error_count;
    int         verdicts_owed;

    logic [7:0] utf8_bytes[$];
    int         beats_sent;
    int         strings_sent;
    bit         no_idle;

    utf8_stream_validator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    utf8_verdict_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .error_count   (error_count),
        .verdicts_owed (verdicts_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (no_idle || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return int'($urandom_range(1, 3));
        end
        if (r < 98)
        begin
            return int'($urandom_range(4, 10));
        end
        return int'($urandom_range(20, 60));
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic last, input logic nobyte);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        s_axis_tuser  <= nobyte;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_string(input bit end_with_nobyte);
        int n;
        bit nobyte_end;
        n = utf8_bytes.size();
        nobyte_end = end_with_nobyte || (n == 0);
        for (int i = 0; i < n; i++)
        begin
            send_beat(utf8_bytes[i], !nobyte_end && (i == n - 1), 1'b0);
        end
        if (nobyte_end)
        begin
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
        strings_sent++;
    endtask

    task automatic wait_all_verdicts();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_owed != 0) @(posedge clk);
    endtask

    task automatic add_code_point();
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        int         r;
        case ($urandom_range(0, 3))
            0:
            begin
                utf8_bytes.push_back(8'($urandom_range(1, 127)));
            end
            1:
            begin
                utf8_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                utf8_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            2:
            begin
                r = int'($urandom_range(0, 5));
                lead = (r == 0) ? 8'hE0 : (r == 1) ? 8'hED :
                       8'($urandom_range(8'hE0, 8'hEF));
                lo = (lead == 8'hE0) ? 8'hA0 : 8'h80;
                hi = (lead == 8'hED) ? 8'h9F : 8'hBF;
                utf8_bytes.push_back(lead);
                utf8_bytes.push_back(8'($urandom_range(lo, hi)));
                utf8_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            default:
            begin
                r = int'($urandom_range(0, 4));
                lead = (r == 0) ? 8'hF0 : (r == 1) ? 8'hF4 :
                       8'($urandom_range(8'hF0, 8'hF4));
                lo = (lead == 8'hF0) ? 8'h90 : 8'h80;
                hi = (lead == 8'hF4) ? 8'h8F : 8'hBF;
                utf8_bytes.push_back(lead);
                utf8_bytes.push_back(8'($urandom_range(lo, hi)));
                utf8_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                utf8_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
        endcase
    endtask

    task automatic break_string();
        int n;
        n = utf8_bytes.size();
        case ($urandom_range(0, 3))
            0:
            begin
                if (n > 0)
                begin
                    utf8_bytes[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
                end
            end
            1:
            begin
                if (n > 0)
                begin
                    utf8_bytes.delete(n - 1);
                end
            end
            2:
            begin
                utf8_bytes.insert(int'($urandom_range(0, n)), 8'($urandom_range(0, 255)));
            end
            default:
            begin
                utf8_bytes.insert(int'($urandom_range(0, n)), 8'h00);
            end
        endcase
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            int stall;
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        int n_chars;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        s_axis_tuser = 1'b0;
        beats_sent = 0;
        strings_sent = 0;
        no_idle = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty string, ascii max, nul, two byte extremes
        utf8_bytes = {};
        send_string(1'b1);
        utf8_bytes = '{8'h7F};
        send_string(1'b0);
        utf8_bytes = '{8'h00};
        send_string(1'b0);
        utf8_bytes = '{8'hC2, 8'h80};
        send_string(1'b0);
        utf8_bytes = '{8'hDF, 8'hBF};
        send_string(1'b0);
        // overlong, surrogate, above max code point, lowest four byte lead and second byte
        utf8_bytes = '{8'hE0, 8'h9F, 8'hBF};
        send_string(1'b0);
        utf8_bytes = '{8'hED, 8'hA0, 8'h80};
        send_string(1'b0);
        utf8_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_string(1'b0);
        utf8_bytes = '{8'hF0, 8'h90, 8'h80, 8'hBF};
        send_string(1'b0);
        // unfinished sequence, then a no-byte beat ending a string with bytes
        utf8_bytes = '{8'h41, 8'hE1};
        send_string(1'b0);
        utf8_bytes = '{8'hFF};
        send_string(1'b1);

        while (beats_sent < BEAT_TARGET)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                no_idle = !no_idle;
            end
            utf8_bytes = {};
            n_chars = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 6));
            repeat (n_chars) add_code_point();
            if ($urandom_range(0, 4) == 0)
            begin
                break_string();
            end
            send_string($urandom_range(0, 6) == 0);
            if (strings_sent % 120 == 0)
            begin
                wait_all_verdicts();
            end
        end

        wait_all_verdicts();
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
